### design/s256_pkg.sv
// sha-256 package: initial hash values, round constants and round functions
// no dependencies
`timescale 1ns / 1ps
package s256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned BlockAw = 6;
  localparam int unsigned LenOffset = 56;

  typedef logic [31:0] word_t;

  function automatic word_t init_word(input logic [2:0] idx);
    word_t r;
    unique case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t ssig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

### design/sha256_stream_hasher_core.sv
// sha-256 core: byte gathering, padding, shared round unit, digest output; needs s256_pkg
// a plain byte is stored; a byte that fills a block starts the rounds and the chaining add
// end of message: a padding walk, the rounds and an add, then 8 output words;
// a marker past byte 55 costs one extra walk and block compression first; a just filled block is compressed first
// throughput: one item at a time, not ready while a block or the digest is in progress
// reset: chaining words to the initial values, byte count to zero, output empty
`timescale 1ns / 1ps
module sha256_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // has_byte
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // digest_word, word_index, zero fill
  output logic        m_tlast    // last_word
);
  import s256_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_RND  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]  state;
  logic [63:0] byte_total;
  word_t       chain [8];
  word_t       v [8];
  word_t       w [16];
  logic [5:0]  cnt;
  logic        final_blk;
  logic        pad_pending;
  logic        pad_first;
  logic [2:0]  oidx;

  word_t t1, t2, wn;
  logic  take;
  logic [5:0] pos;
  logic [5:0] pos_next;
  logic [63:0] bits;

  assign s_tready = (state == ST_IDLE);
  assign take = s_tvalid && s_tready;
  assign pos = byte_total[BlockAw-1:0];
  assign pos_next = pos + {5'd0, s_tuser};
  assign bits = {byte_total[60:0], 3'b000};

  assign wn = ssig1(w[14]) + w[9] + ssig0(w[1]) + w[0];
  assign t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[cnt] + w[0];
  assign t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  assign m_tvalid = (state == ST_OUT);
  assign m_tdata = {5'd0, oidx, chain[oidx]};
  assign m_tlast = (oidx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      byte_total <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= init_word(3'(i));
      cnt <= '0;
      final_blk <= 1'b0;
      pad_pending <= 1'b0;
      pad_first <= 1'b0;
      oidx <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            if (s_tuser) begin
              w[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= s_tdata;
              byte_total <= byte_total + 64'd1;
            end
            if (s_tuser && pos == 6'd63) begin
              for (int i = 0; i < 8; i++) v[i] <= chain[i];
              cnt <= '0;
              final_blk <= 1'b0;
              pad_pending <= s_tlast;
              pad_first <= 1'b1;
              state <= ST_RND;
            end else if (s_tlast) begin
              cnt <= pos_next;
              pad_first <= 1'b1;
              final_blk <= (pos_next < 6'(LenOffset));
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (final_blk && cnt == 6'(LenOffset)) begin
            w[14] <= bits[63:32];
            w[15] <= bits[31:0];
            for (int i = 0; i < 8; i++) v[i] <= chain[i];
            cnt <= '0;
            state <= ST_RND;
          end else begin
            w[cnt[5:2]][{~cnt[1:0], 3'b000} +: 8] <= pad_first ? 8'h80 : 8'h00;
            pad_first <= 1'b0;
            if (cnt == 6'd63) begin
              for (int i = 0; i < 8; i++) v[i] <= chain[i];
              pad_pending <= 1'b1;
              state <= ST_RND;
            end
            cnt <= cnt + 6'd1;
          end
        end
        ST_RND: begin
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wn;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) state <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
          if (final_blk) begin
            oidx <= '0;
            state <= ST_OUT;
          end else if (pad_pending) begin
            pad_pending <= 1'b0;
            final_blk <= 1'b1;
            cnt <= '0;
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              for (int i = 0; i < 8; i++) chain[i] <= init_word(3'(i));
              byte_total <= '0;
              final_blk <= 1'b0;
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
